// ----- rtl/sc2asc_pkg.sv -----
// Package for the scancode set 1 to ASCII decoder.
// Holds the key-state flag type, scancode constants and the two lookup tables.
// No dependencies.
`default_nettype none

package sc2asc_pkg;

    localparam int ScanWidth  = 8;
    localparam int AsciiWidth = 7;
    localparam int KeyWidth   = 7;

    localparam logic [ScanWidth-1:0]  SC_PREFIX = 8'hE0;
    localparam logic [KeyWidth-1:0]   SC_LSHIFT = 7'h2A;
    localparam logic [KeyWidth-1:0]   SC_RSHIFT = 7'h36;
    localparam logic [KeyWidth-1:0]   SC_CAPS   = 7'h3A;

    localparam logic [AsciiWidth-1:0] CH_NONE    = 7'h00;
    localparam logic [AsciiWidth-1:0] CH_LOWER_A = 7'h61;
    localparam logic [AsciiWidth-1:0] CH_LOWER_Z = 7'h7A;
    localparam logic [AsciiWidth-1:0] CH_UPPER_A = 7'h41;
    localparam logic [AsciiWidth-1:0] CH_UPPER_Z = 7'h5A;
    localparam logic [AsciiWidth-1:0] CH_CASE    = 7'h20;

    typedef struct packed {
        logic shift_held;
        logic caps_active;
        logic prefix_pending;
    } sc2asc_flags_t;

    function automatic logic [AsciiWidth-1:0] plain_char(input logic [KeyWidth-1:0] key);
        logic [AsciiWidth-1:0] ch;
        case (key)
            7'h01: ch = 7'h1B;
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;
            7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61;
            7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;
            7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic [AsciiWidth-1:0] upper_char(input logic [KeyWidth-1:0] key);
        logic [AsciiWidth-1:0] ch;
        case (key)
            7'h01: ch = 7'h1B;
            7'h02: ch = 7'h21;
            7'h03: ch = 7'h40;
            7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;
            7'h07: ch = 7'h5E;
            7'h08: ch = 7'h26;
            7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28;
            7'h0B: ch = 7'h29;
            7'h0C: ch = 7'h5F;
            7'h0D: ch = 7'h2B;
            7'h0E: ch = 7'h08;
            7'h0F: ch = 7'h09;
            7'h10: ch = 7'h51;
            7'h11: ch = 7'h57;
            7'h12: ch = 7'h45;
            7'h13: ch = 7'h52;
            7'h14: ch = 7'h54;
            7'h15: ch = 7'h59;
            7'h16: ch = 7'h55;
            7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F;
            7'h19: ch = 7'h50;
            7'h1A: ch = 7'h7B;
            7'h1B: ch = 7'h7D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h41;
            7'h1F: ch = 7'h53;
            7'h20: ch = 7'h44;
            7'h21: ch = 7'h46;
            7'h22: ch = 7'h47;
            7'h23: ch = 7'h48;
            7'h24: ch = 7'h4A;
            7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C;
            7'h27: ch = 7'h3A;
            7'h28: ch = 7'h22;
            7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;
            7'h2C: ch = 7'h5A;
            7'h2D: ch = 7'h58;
            7'h2E: ch = 7'h43;
            7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42;
            7'h31: ch = 7'h4E;
            7'h32: ch = 7'h4D;
            7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E;
            7'h35: ch = 7'h3F;
            7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sc2asc_decode.sv -----
// Combinational decode of one scancode byte against the current key flags.
// Produces the character and the updated flags. Depends on sc2asc_pkg.
`default_nettype none

module sc2asc_decode
    import sc2asc_pkg::*;
(
    input  wire logic [ScanWidth-1:0]  scan_byte,
    input  wire sc2asc_flags_t         flags,
    output sc2asc_flags_t              flags_next,
    output logic [AsciiWidth-1:0]      ascii_char
);

    logic [KeyWidth-1:0]   key;
    logic                  is_shift;
    logic [AsciiWidth-1:0] lookup;

    assign key      = scan_byte[KeyWidth-1:0];
    assign is_shift = (key == SC_LSHIFT) || (key == SC_RSHIFT);
    assign lookup   = flags.shift_held ? upper_char(key) : plain_char(key);

    always_comb begin
        flags_next = flags;
        ascii_char = CH_NONE;
        if (scan_byte == SC_PREFIX) begin
            flags_next.prefix_pending = 1'b1;
        end else if (scan_byte[ScanWidth-1]) begin
            if (is_shift) begin
                flags_next.shift_held = 1'b0;
            end
            flags_next.prefix_pending = 1'b0;
        end else if (is_shift) begin
            flags_next.shift_held = 1'b1;
        end else if (key == SC_CAPS) begin
            flags_next.caps_active = ~flags.caps_active;
        end else if (flags.prefix_pending) begin
            flags_next.prefix_pending = 1'b0;
        end else begin
            ascii_char = lookup;
            if (flags.caps_active) begin
                if (!flags.shift_held && lookup >= CH_LOWER_A && lookup <= CH_LOWER_Z) begin
                    ascii_char = lookup - CH_CASE;
                end else if (flags.shift_held && lookup >= CH_UPPER_A
                             && lookup <= CH_UPPER_Z) begin
                    ascii_char = lookup + CH_CASE;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/scancode_to_ascii_decoder_core.sv -----
// Top level of the scancode set 1 to ASCII decoder: input register, key flags,
// result register. Depends on sc2asc_pkg and sc2asc_decode.
//
//   channel | ports                       | width | direction
//   s_      | s_valid s_ready s_scan_byte | 8     | in
//   m_      | m_valid m_ready m_ascii_char| 7     | out
//
// One item per cycle while m_ready is high; an item reaches m_ via the result register.
// The input register and the result register are decoupled, so one item is still
// taken while a result waits on m_ready. Flags update as an item moves from the
// input register into the result register. aresetn (synchronous) clears valids
// and flags.
`default_nettype none

module scancode_to_ascii_decoder_core
    import sc2asc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ScanWidth-1:0]  s_scan_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [AsciiWidth-1:0]      m_ascii_char
);

    logic                  in_valid_reg;
    logic [ScanWidth-1:0]  in_byte_reg;
    logic                  out_valid_reg;
    logic [AsciiWidth-1:0] out_char_reg;
    sc2asc_flags_t         flags_reg;
    sc2asc_flags_t         flags_next;
    logic [AsciiWidth-1:0] char_next;
    logic                  out_free;
    logic                  dec_fire;
    logic                  s_fire;

    assign out_free = !out_valid_reg || m_ready;
    assign dec_fire = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    sc2asc_decode u_decode (
        .scan_byte  (in_byte_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .ascii_char (char_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (dec_fire) begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_scan_byte;
        end
        if (dec_fire) begin
            out_char_reg <= char_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_ascii_char = out_char_reg;

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free slot");

    a_prefix_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_fire && in_byte_reg == SC_PREFIX) |=> flags_reg.prefix_pending)
        else $error("prefix byte did not set the prefix flag");

    a_break_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_fire && in_byte_reg[ScanWidth-1]) |=> (m_ascii_char == CH_NONE))
        else $error("break code produced a character");

    a_caps_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_fire && in_byte_reg == {1'b0, SC_CAPS})
        |=> (flags_reg.caps_active != $past(flags_reg.caps_active)))
        else $error("caps lock make did not toggle caps");

endmodule

`default_nettype wire

// ----- dv/ascii_result_checker.sv -----
// Checker for the scancode to ASCII decoder: watches both channels, keeps its own
// shift / caps / prefix flags and compares every result item in order.
// Depends on sc2asc_pkg for widths, scancode constants and the flag struct.
`timescale 1ns / 100ps

module ascii_result_checker
    import sc2asc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [ScanWidth-1:0]  s_scan_byte,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [AsciiWidth-1:0] m_ascii_char,
    output int                         fail_count,
    output int                         chars_pending
);

    localparam int KEY_ROWS = 58;

    logic [AsciiWidth-1:0] lower_keys [0:KEY_ROWS-1];
    logic [AsciiWidth-1:0] upper_keys [0:KEY_ROWS-1];
    sc2asc_flags_t         key_flags;
    logic [AsciiWidth-1:0] expected_chars [$];

    initial begin
        lower_keys = '{
            7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
            7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
            7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
            7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
            7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
            7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
            7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
            7'h00, 7'h20
        };
        upper_keys = '{
            7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
            7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
            7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
            7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
            7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
            7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
            7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
            7'h00, 7'h20
        };
    end

    function automatic logic [AsciiWidth-1:0] decode_scan(input logic [ScanWidth-1:0] code);
        logic [KeyWidth-1:0]   key;
        logic [AsciiWidth-1:0] ch;
        key = code[KeyWidth-1:0];
        ch  = CH_NONE;
        if (code == SC_PREFIX) begin
            key_flags.prefix_pending = 1'b1;
        end else if (code[ScanWidth-1]) begin
            if (key == SC_LSHIFT || key == SC_RSHIFT) begin
                key_flags.shift_held = 1'b0;
            end
            key_flags.prefix_pending = 1'b0;
        end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
            key_flags.shift_held = 1'b1;
        end else if (key == SC_CAPS) begin
            key_flags.caps_active = ~key_flags.caps_active;
        end else if (key_flags.prefix_pending) begin
            key_flags.prefix_pending = 1'b0;
        end else begin
            if (int'(key) < KEY_ROWS) begin
                ch = key_flags.shift_held ? upper_keys[key[5:0]] : lower_keys[key[5:0]];
            end
            if (key_flags.caps_active) begin
                if (!key_flags.shift_held && ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
                    ch = ch - CH_CASE;
                end else if (key_flags.shift_held && ch >= CH_UPPER_A
                             && ch <= CH_UPPER_Z) begin
                    ch = ch + CH_CASE;
                end
            end
        end
        return ch;
    endfunction

    always @(posedge aclk) begin
        logic [AsciiWidth-1:0] want;
        if (!aresetn) begin
            key_flags = '0;
            expected_chars.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("m_ascii_char: item with none expected, actual %h", m_ascii_char);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_ascii_char !== want) begin
                        $error("m_ascii_char: expected %h, actual %h", want, m_ascii_char);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_chars.push_back(decode_scan(s_scan_byte));
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

// ----- dv/tb_scancode_to_ascii_decoder_core.sv -----
// Top of the decoder testbench: clock, reset, scancode stimulus with random gaps,
// random result back-pressure, watchdog and verdict.
// Depends on sc2asc_pkg, scancode_to_ascii_decoder_core and ascii_result_checker.
`timescale 1ns / 100ps

module tb_scancode_to_ascii_decoder_core;
    import sc2asc_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_EVERY = 400;
    localparam int DIRECTED_LEN = 26;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ScanWidth-1:0]  s_scan_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [AsciiWidth-1:0] m_ascii_char;
    int                    fail_count;
    int                    chars_pending;

    int                    items_sent = 0;
    int                    calm_left = 0;
    int                    quiet_cycles = 0;
    logic [ScanWidth-1:0]  directed_bytes [0:DIRECTED_LEN-1];

    scancode_to_ascii_decoder_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_scan_byte  (s_scan_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char)
    );

    ascii_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_scan_byte   (s_scan_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_char  (m_ascii_char),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    // result side: stalls of random length, with occasional long free runs
    initial begin
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (free_left > 0) begin
                    free_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = idle_len();
                end else if ($urandom_range(0, 49) == 0) begin
                    free_left = $urandom_range(30, 120);
                end
            end
        end
    end

    function automatic int sender_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm_left = $urandom_range(20, 100);
            return 0;
        end
        if ($urandom_range(0, 2) != 0) begin
            return 0;
        end
        return idle_len();
    endfunction

    task automatic send_scan(input logic [ScanWidth-1:0] code);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_scan_byte <= code;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic drain_results();
        @(negedge aclk) s_valid <= 1'b0;
        while (chars_pending != 0) @(negedge aclk);
    endtask

    initial begin
        logic [ScanWidth-1:0] key;
        logic [ScanWidth-1:0] shift_key;
        int                   r;
        int                   next_drain;

        directed_bytes = '{
            8'h00, 8'hFF, 8'h1E, 8'h2A, 8'h1E, 8'h02, 8'hAA, 8'h3A,
            8'h1E, 8'h36, 8'h1E, 8'hB6, 8'hE0, 8'hE0, 8'h2A, 8'h1C,
            8'hAA, 8'hE0, 8'h3A, 8'h10, 8'h10, 8'h3B, 8'h7F, 8'h39,
            8'hE0, 8'h9C
        };
        next_drain = DRAIN_EVERY;

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_scan(directed_bytes[i]);
        end
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            key = 8'($urandom_range(1, 8'h58));
            shift_key = $urandom_range(0, 1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT};
            if (r < 45) begin
                send_scan(key);
                send_scan(key | 8'h80);
            end else if (r < 60) begin
                send_scan(shift_key);
                send_scan(key);
                send_scan(key | 8'h80);
                send_scan(shift_key | 8'h80);
            end else if (r < 68) begin
                send_scan({1'b0, SC_CAPS});
                send_scan({1'b1, SC_CAPS});
            end else if (r < 80) begin
                key = 8'($urandom_range(0, 8'h7F));
                send_scan(SC_PREFIX);
                send_scan(key);
                send_scan(SC_PREFIX);
                send_scan(key | 8'h80);
            end else begin
                send_scan(8'($urandom_range(0, 255)));
            end
            if (items_sent >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
        end

        drain_results();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
